/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define OBB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define OBB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/obb_pkg.sv */
package obb_pkg;

    localparam int CoordW  = 24;              // Q15.8 center
    localparam int DiffW   = CoordW + 1;      // center difference
    localparam int HalfW   = 23;              // half extent
    localparam int DirW    = 16;              // Q1.14 axis component
    localparam int PDirW   = 2 * DirW;        // axis component product
    localparam int DotW    = PDirW + 1;       // axis dot axis, signed
    localparam int MagW    = PDirW;           // |axis dot axis|
    localparam int ProdW   = DiffW + DirW;    // d component times axis component
    localparam int SumW    = ProdW + 1;       // d dot axis, signed
    localparam int DistW   = ProdW;           // |d dot axis|
    localparam int RadW    = MagW + HalfW;    // projected half extent
    localparam int BoundW  = RadW + 1;        // sum of projected half extents
    localparam int ShiftD  = 14;              // d dot axis to Q.36
    localparam int ShiftH  = 28;              // own half size to Q.36
    localparam int Depth   = 5;               // register stages

    typedef struct packed {
        logic signed [ProdW-1:0] pa;     // first distance product
        logic signed [ProdW-1:0] pb;     // second distance product
        logic                    neg;    // pa - pb instead of pa + pb
        logic [HalfW-1:0]        own;    // half size along the tested axis
        logic [MagW-1:0]         c1;
        logic [HalfW-1:0]        h1;
        logic [MagW-1:0]         c2;
        logic [HalfW-1:0]        h2;
    } obb_axis_t;

    function automatic logic [MagW-1:0] dot_mag(input logic signed [DotW-1:0] v);
        logic signed [DotW-1:0] n;
        n = -v;
        return v[DotW-1] ? n[MagW-1:0] : v[MagW-1:0];
    endfunction

    function automatic logic [DistW-1:0] dist_mag(input logic signed [SumW-1:0] v);
        logic signed [SumW-1:0] n;
        n = -v;
        return v[SumW-1] ? n[DistW-1:0] : v[DistW-1:0];
    endfunction

endpackage

/* rtl/obb_axis.sv */
// One separating axis: stages three to five.
module obb_axis (
    input  logic              clk,
    input  logic              en,
    input  obb_pkg::obb_axis_t axis_in,
    output logic              sep
);

    logic signed [obb_pkg::SumW-1:0]  dsum;
    logic [obb_pkg::DistW-1:0]        dist_next;
    logic [obb_pkg::DistW-1:0]        dist_reg;
    logic [obb_pkg::RadW-1:0]         r1_next;
    logic [obb_pkg::RadW-1:0]         r2_next;
    logic [obb_pkg::RadW-1:0]         r1_reg;
    logic [obb_pkg::RadW-1:0]         r2_reg;
    logic [obb_pkg::HalfW-1:0]        own_reg;
    logic [obb_pkg::BoundW-1:0]       dsh_next;
    logic [obb_pkg::BoundW-1:0]       bound_next;
    logic [obb_pkg::BoundW-1:0]       dsh_reg;
    logic [obb_pkg::BoundW-1:0]       bound_reg;
    logic                             sep_next;
    logic                             sep_reg;

    // stage 3: distance along the axis, projected half extents
    always_comb
    begin
        if (axis_in.neg)
        begin
            dsum = {axis_in.pa[obb_pkg::ProdW-1], axis_in.pa}
                 - {axis_in.pb[obb_pkg::ProdW-1], axis_in.pb};
        end
        else
        begin
            dsum = {axis_in.pa[obb_pkg::ProdW-1], axis_in.pa}
                 + {axis_in.pb[obb_pkg::ProdW-1], axis_in.pb};
        end
        dist_next = obb_pkg::dist_mag(dsum);
    end

    assign r1_next = obb_pkg::RadW'(axis_in.c1) * obb_pkg::RadW'(axis_in.h1);
    assign r2_next = obb_pkg::RadW'(axis_in.c2) * obb_pkg::RadW'(axis_in.h2);

    // stage 4: align to Q.36 and add up the bound
    assign dsh_next   = obb_pkg::BoundW'(dist_reg) << obb_pkg::ShiftD;
    assign bound_next = (obb_pkg::BoundW'(own_reg) << obb_pkg::ShiftH)
                      + obb_pkg::BoundW'(r1_reg) + obb_pkg::BoundW'(r2_reg);

    // stage 5: strict compare, touching is no separation
    assign sep_next = dsh_reg > bound_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg  <= dist_next;
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            own_reg   <= axis_in.own;
            dsh_reg   <= dsh_next;
            bound_reg <= bound_next;
            sep_reg   <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

/* rtl/obb_overlap_test_2d.sv */
// Oriented rectangle overlap test, separating axis test over four axes.
// An accepted word passes through five register stages before its overlap is shown.
// Throughput: one word per cycle; the five stages advance together and
// freeze only while a result waits on out_stall.
// Reset: rst_n (async, active low) clears the stage valid bits only.
module obb_overlap_test_2d (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [obb_pkg::CoordW-1:0]   a_center_x,
    input  logic signed [obb_pkg::CoordW-1:0]   a_center_y,
    input  logic        [obb_pkg::HalfW-1:0]    a_half_width,
    input  logic        [obb_pkg::HalfW-1:0]    a_half_height,
    input  logic signed [obb_pkg::DirW-1:0]     a_dir_x,
    input  logic signed [obb_pkg::DirW-1:0]     a_dir_y,
    input  logic signed [obb_pkg::CoordW-1:0]   b_center_x,
    input  logic signed [obb_pkg::CoordW-1:0]   b_center_y,
    input  logic        [obb_pkg::HalfW-1:0]    b_half_width,
    input  logic        [obb_pkg::HalfW-1:0]    b_half_height,
    input  logic signed [obb_pkg::DirW-1:0]     b_dir_x,
    input  logic signed [obb_pkg::DirW-1:0]     b_dir_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                overlap
);

    // Whole pipe moves as one; only a held result at the output stops it.
    logic                               en;
    logic [obb_pkg::Depth-1:0]          vld_reg;

    // stage 1: center difference, axis component products
    logic signed [obb_pkg::DiffW-1:0]   dx_next, dy_next, dx_reg, dy_reg;
    logic signed [obb_pkg::PDirW-1:0]   pxx_next, pyy_next, pxy_next, pyx_next;
    logic signed [obb_pkg::PDirW-1:0]   pxx_reg, pyy_reg, pxy_reg, pyx_reg;
    logic signed [obb_pkg::DirW-1:0]    aux_reg, auy_reg, bux_reg, buy_reg;
    logic [obb_pkg::HalfW-1:0]          ahw1_reg, ahh1_reg, bhw1_reg, bhh1_reg;

    // stage 2: |au.bu| (equals |av.bv|), |av.bu| (equals |au.bv|),
    // and the eight d-component products
    logic signed [obb_pkg::DotW-1:0]    cuu, cvu;
    logic [obb_pkg::MagW-1:0]           muu_reg, mvu_reg;
    logic signed [obb_pkg::ProdW-1:0]   dx_aux_reg, dy_auy_reg, dy_aux_reg, dx_auy_reg;
    logic signed [obb_pkg::ProdW-1:0]   dx_bux_reg, dy_buy_reg, dy_bux_reg, dx_buy_reg;
    logic [obb_pkg::HalfW-1:0]          ahw2_reg, ahh2_reg, bhw2_reg, bhh2_reg;

    obb_pkg::obb_axis_t                 ax_au, ax_av, ax_bu, ax_bv;
    logic                               sep_au, sep_av, sep_bu, sep_bv;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[obb_pkg::Depth-2:0], in_valid};
        end
    end

    assign dx_next  = {a_center_x[obb_pkg::CoordW-1], a_center_x}
                    - {b_center_x[obb_pkg::CoordW-1], b_center_x};
    assign dy_next  = {a_center_y[obb_pkg::CoordW-1], a_center_y}
                    - {b_center_y[obb_pkg::CoordW-1], b_center_y};
    assign pxx_next = obb_pkg::PDirW'(a_dir_x) * obb_pkg::PDirW'(b_dir_x);
    assign pyy_next = obb_pkg::PDirW'(a_dir_y) * obb_pkg::PDirW'(b_dir_y);
    assign pxy_next = obb_pkg::PDirW'(a_dir_x) * obb_pkg::PDirW'(b_dir_y);
    assign pyx_next = obb_pkg::PDirW'(a_dir_y) * obb_pkg::PDirW'(b_dir_x);

    // au.bu = ax*bx + ay*by ; av.bu = ax*by - ay*bx (av = (-ay, ax))
    assign cuu = {pxx_reg[obb_pkg::PDirW-1], pxx_reg} + {pyy_reg[obb_pkg::PDirW-1], pyy_reg};
    assign cvu = {pxy_reg[obb_pkg::PDirW-1], pxy_reg} - {pyx_reg[obb_pkg::PDirW-1], pyx_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            pxx_reg    <= pxx_next;
            pyy_reg    <= pyy_next;
            pxy_reg    <= pxy_next;
            pyx_reg    <= pyx_next;
            aux_reg    <= a_dir_x;
            auy_reg    <= a_dir_y;
            bux_reg    <= b_dir_x;
            buy_reg    <= b_dir_y;
            ahw1_reg   <= a_half_width;
            ahh1_reg   <= a_half_height;
            bhw1_reg   <= b_half_width;
            bhh1_reg   <= b_half_height;

            muu_reg    <= obb_pkg::dot_mag(cuu);
            mvu_reg    <= obb_pkg::dot_mag(cvu);
            dx_aux_reg <= obb_pkg::ProdW'(dx_reg) * obb_pkg::ProdW'(aux_reg);
            dy_auy_reg <= obb_pkg::ProdW'(dy_reg) * obb_pkg::ProdW'(auy_reg);
            dy_aux_reg <= obb_pkg::ProdW'(dy_reg) * obb_pkg::ProdW'(aux_reg);
            dx_auy_reg <= obb_pkg::ProdW'(dx_reg) * obb_pkg::ProdW'(auy_reg);
            dx_bux_reg <= obb_pkg::ProdW'(dx_reg) * obb_pkg::ProdW'(bux_reg);
            dy_buy_reg <= obb_pkg::ProdW'(dy_reg) * obb_pkg::ProdW'(buy_reg);
            dy_bux_reg <= obb_pkg::ProdW'(dy_reg) * obb_pkg::ProdW'(bux_reg);
            dx_buy_reg <= obb_pkg::ProdW'(dx_reg) * obb_pkg::ProdW'(buy_reg);
            ahw2_reg   <= ahw1_reg;
            ahh2_reg   <= ahh1_reg;
            bhw2_reg   <= bhw1_reg;
            bhh2_reg   <= bhh1_reg;
        end
    end

    // Axis setups. d.av = dy*ax - dx*ay, d.bv likewise.
    always_comb
    begin
        ax_au = '{pa: dx_aux_reg, pb: dy_auy_reg, neg: 1'b0, own: ahw2_reg,
                  c1: muu_reg, h1: bhw2_reg, c2: mvu_reg, h2: bhh2_reg};
        ax_av = '{pa: dy_aux_reg, pb: dx_auy_reg, neg: 1'b1, own: ahh2_reg,
                  c1: mvu_reg, h1: bhw2_reg, c2: muu_reg, h2: bhh2_reg};
        ax_bu = '{pa: dx_bux_reg, pb: dy_buy_reg, neg: 1'b0, own: bhw2_reg,
                  c1: muu_reg, h1: ahw2_reg, c2: mvu_reg, h2: ahh2_reg};
        ax_bv = '{pa: dy_bux_reg, pb: dx_buy_reg, neg: 1'b1, own: bhh2_reg,
                  c1: mvu_reg, h1: ahw2_reg, c2: muu_reg, h2: ahh2_reg};
    end

    obb_axis u_axis_au (.clk(clk), .en(en), .axis_in(ax_au), .sep(sep_au));
    obb_axis u_axis_av (.clk(clk), .en(en), .axis_in(ax_av), .sep(sep_av));
    obb_axis u_axis_bu (.clk(clk), .en(en), .axis_in(ax_bu), .sep(sep_bu));
    obb_axis u_axis_bv (.clk(clk), .en(en), .axis_in(ax_bv), .sep(sep_bv));

    // Overlap unless any axis separates.
    assign overlap   = !(sep_au || sep_av || sep_bu || sep_bv);
    assign out_valid = vld_reg[obb_pkg::Depth-1];

endmodule

/* rtl/obb_checker.sv */
`include "assert_macros.svh"

module obb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic overlap
);

    `OBB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")
    `OBB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(overlap), "held word changed")
    `OBB_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall), "input stalled without cause")
    `OBB_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 (!in_stall) [*4], out_valid, "missing")

endmodule

bind obb_overlap_test_2d obb_checker u_obb_checker (.*);
